### sv/cec_pkg.sv
// Shared types, constants and calendar helper functions for the epoch converter.
package cec_pkg;

   localparam logic [11:0] EPOCH_YEAR = 12'd1970;
   localparam logic [11:0] YEAR_BEFORE_EPOCH = 12'd1969;
   localparam logic [20:0] LEAP_OFFSET = 21'd477;
   // Reciprocals rounded up: 2^35 / 675, 2^21 / 225 and 2^14 / 15.
   localparam logic [25:0] DAY_RECIP = 26'd50903317;
   localparam logic [13:0] HOUR_RECIP = 14'd9321;
   localparam logic [10:0] MIN_RECIP = 11'd1093;
   localparam logic [16:0] SECS_PER_DAY = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0] SECS_PER_MIN = 6'd60;
   localparam logic [3:0] LAST_MONTH = 4'd12;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_M0_DAYS,
      OP_M0_H,
      OP_M0_M,
      OP_M0_S,
      OP_DIV_DAY,
      OP_DAY_DONE,
      OP_DIV_HOUR,
      OP_HOUR_DONE,
      OP_DIV_MIN,
      OP_MIN_DONE,
      OP_SRCH_MID,
      OP_SRCH_CMP,
      OP_YEAR_SUB,
      OP_MON_INIT,
      OP_MON_STEP,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type     op;
   } cmd_type;

   typedef struct packed {
      logic srch_done;
      logic mon_done;
   } stat_type;

   function automatic logic [4:0] month_len(input logic [3:0] m);
      logic [4:0] r;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
         4'd2: r = 5'd28;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // Days in a common year before the first of the month.
   function automatic logic [8:0] month_start(input logic [3:0] m);
      logic [8:0] r;
      unique case (m)
         4'd1: r = 9'd0;
         4'd2: r = 9'd31;
         4'd3: r = 9'd59;
         4'd4: r = 9'd90;
         4'd5: r = 9'd120;
         4'd6: r = 9'd151;
         4'd7: r = 9'd181;
         4'd8: r = 9'd212;
         4'd9: r = 9'd243;
         4'd10: r = 9'd273;
         4'd11: r = 9'd304;
         4'd12: r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Exact for every 12-bit value.
   function automatic logic [11:0] div100(input logic [11:0] y);
      logic [24:0] p;
      p = 25'(y) * 25'd5243;
      return 12'(p[24:19]);
   endfunction

   function automatic logic is_leap(input logic [11:0] y);
      logic [11:0] q;
      logic [18:0] back;
      q = div100(y);
      back = 19'(q) * 19'd100;
      if (19'(y) == back) begin
         return q[1:0] == 2'b00;
      end
      return y[1:0] == 2'b00;
   endfunction

   // Days from the epoch to January 1 of year 1970 + n, where y = 1969 + n.
   function automatic logic [20:0] days_before(input logic [11:0] n, input logic [11:0] y);
      logic [20:0] base;
      logic [11:0] y4;
      base = 21'(n) * 21'd365;
      y4 = y >> 2;
      return base + 21'(y4) - 21'(div100(y)) + 21'(div100(y4)) - LEAP_OFFSET;
   endfunction

   // Remainder modulo 7 by folding octal digits, since 8 is 1 modulo 7.
   function automatic logic [2:0] mod7(input logic [15:0] x);
      logic [5:0] s;
      logic [3:0] f;
      s = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) + 6'(x[15]);
      f = 4'(s[5:3]) + 4'(s[2:0]);
      if (f >= 4'd7) begin
         f = f - 4'd7;
      end
      return f[2:0];
   endfunction

endpackage

### sv/calendar_epoch_converter.sv
// Top level of the calendar to epoch-seconds converter.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  mode, calendar fields, epoch_seconds
//   rsp      out        rsp_valid/rsp_ready  status, out_* fields, weekday
//
// Calendar to seconds runs a day-count step and then three multiply-add stages.
// Seconds to calendar runs the reciprocal divides by 86400, 3600 and 60, then a
// binary year search whose steps pass through test, midpoint and compare, then
// a month scan. The result register frees the unit once loaded; a new
// transaction is taken while the previous result still waits on rsp_ready.
// Reset is synchronous.
module calendar_epoch_converter
   import cec_pkg::*;
#(
   parameter int YEAR_SEARCH_SPAN = 256
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [11:0] req_year,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [5:0]  req_second,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [31:0] rsp_out_seconds,
   output logic [11:0] rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic [4:0]  rsp_out_hour,
   output logic [5:0]  rsp_out_minute,
   output logic [5:0]  rsp_out_second,
   output logic [2:0]  rsp_weekday
);

   cmd_type  cmd;
   stat_type stat;

   cec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   cec_datapath #(
      .YEAR_SEARCH_SPAN (YEAR_SEARCH_SPAN)
   ) u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .stat              (stat),
      .req_mode          (req_mode),
      .req_year          (req_year),
      .req_month         (req_month),
      .req_day           (req_day),
      .req_hour          (req_hour),
      .req_minute        (req_minute),
      .req_second        (req_second),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_status        (rsp_status),
      .rsp_out_seconds   (rsp_out_seconds),
      .rsp_out_year      (rsp_out_year),
      .rsp_out_month     (rsp_out_month),
      .rsp_out_day       (rsp_out_day),
      .rsp_out_hour      (rsp_out_hour),
      .rsp_out_minute    (rsp_out_minute),
      .rsp_out_second    (rsp_out_second),
      .rsp_weekday       (rsp_weekday)
   );

endmodule

### sv/cec_ctrl.sv
// Controller state machine that sequences the converter datapath.
module cec_ctrl
   import cec_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_mode,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output cmd_type  cmd,
   input  stat_type stat
);

   typedef enum logic [17:0] {
      ST_IDLE      = 18'b000000000000000001,
      ST_M0_DAYS   = 18'b000000000000000010,
      ST_M0_H      = 18'b000000000000000100,
      ST_M0_M      = 18'b000000000000001000,
      ST_M0_S      = 18'b000000000000010000,
      ST_DIV_DAY   = 18'b000000000000100000,
      ST_DAY_DONE  = 18'b000000000001000000,
      ST_DIV_HOUR  = 18'b000000000010000000,
      ST_HOUR_DONE = 18'b000000000100000000,
      ST_DIV_MIN   = 18'b000000001000000000,
      ST_MIN_DONE  = 18'b000000010000000000,
      ST_SRCH_TEST = 18'b000000100000000000,
      ST_SRCH_MID  = 18'b000001000000000000,
      ST_SRCH_CMP  = 18'b000010000000000000,
      ST_YEAR_SUB  = 18'b000100000000000000,
      ST_MON_INIT  = 18'b001000000000000000,
      ST_MON_STEP  = 18'b010000000000000000,
      ST_FINISH    = 18'b100000000000000000
   } state_type;

   state_type  state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_ready;
      cmd.op = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               state_in = req_mode ? ST_DIV_DAY : ST_M0_DAYS;
            end
         end
         ST_M0_DAYS: begin
            cmd.op = OP_M0_DAYS;
            state_in = ST_M0_H;
         end
         ST_M0_H: begin
            cmd.op = OP_M0_H;
            state_in = ST_M0_M;
         end
         ST_M0_M: begin
            cmd.op = OP_M0_M;
            state_in = ST_M0_S;
         end
         ST_M0_S: begin
            cmd.op = OP_M0_S;
            state_in = ST_FINISH;
         end
         ST_DIV_DAY: begin
            cmd.op = OP_DIV_DAY;
            state_in = ST_DAY_DONE;
         end
         ST_DAY_DONE: begin
            cmd.op = OP_DAY_DONE;
            state_in = ST_DIV_HOUR;
         end
         ST_DIV_HOUR: begin
            cmd.op = OP_DIV_HOUR;
            state_in = ST_HOUR_DONE;
         end
         ST_HOUR_DONE: begin
            cmd.op = OP_HOUR_DONE;
            state_in = ST_DIV_MIN;
         end
         ST_DIV_MIN: begin
            cmd.op = OP_DIV_MIN;
            state_in = ST_MIN_DONE;
         end
         ST_MIN_DONE: begin
            cmd.op = OP_MIN_DONE;
            state_in = ST_SRCH_TEST;
         end
         ST_SRCH_TEST: begin
            state_in = stat.srch_done ? ST_YEAR_SUB : ST_SRCH_MID;
         end
         ST_SRCH_MID: begin
            cmd.op = OP_SRCH_MID;
            state_in = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            cmd.op = OP_SRCH_CMP;
            state_in = ST_SRCH_TEST;
         end
         ST_YEAR_SUB: begin
            cmd.op = OP_YEAR_SUB;
            state_in = ST_MON_INIT;
         end
         ST_MON_INIT: begin
            cmd.op = OP_MON_INIT;
            state_in = ST_MON_STEP;
         end
         ST_MON_STEP: begin
            cmd.op = OP_MON_STEP;
            if (stat.mon_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.op = OP_OUT;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

### sv/cec_datapath.sv
// Datapath: operand registers, constant divides, year search, month scan and result register.
module cec_datapath
   import cec_pkg::*;
#(
   parameter int YEAR_SEARCH_SPAN = 256
)
(
   input  logic        clock,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic        req_mode,
   input  logic [11:0] req_year,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [5:0]  req_second,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_status,
   output logic [31:0] rsp_out_seconds,
   output logic [11:0] rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic [4:0]  rsp_out_hour,
   output logic [5:0]  rsp_out_minute,
   output logic [5:0]  rsp_out_second,
   output logic [2:0]  rsp_weekday
);

   localparam int SW = $clog2(YEAR_SEARCH_SPAN + 1);

   logic        mode_ff;
   logic [11:0] year_ff;
   logic [3:0]  month_ff;
   logic [4:0]  day_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [5:0]  second_ff;
   logic [31:0] s_ff;
   logic        err_ff;
   logic [20:0] days0_ff;
   logic [31:0] t_ff;
   logic [16:0] r_ff;
   logic [15:0] days_ff;
   logic [2:0]  wd_ff;
   logic [SW-1:0] lo_ff, hi_ff, mid_ff;
   logic [20:0] dbmid_ff;
   logic [15:0] dayr_ff;
   logic [11:0] oyear_ff;
   logic        leap_ff;
   logic [8:0]  acc_ff;
   logic [3:0]  mi_ff;
   logic [3:0]  mon_ff;

   logic [50:0] day_prod;
   logic [26:0] hour_prod;
   logic [20:0] min_prod;
   logic        leap0;
   logic [5:0]  lim;
   logic        bad;
   logic [SW:0] mid_sum;
   logic [20:0] db_lo;
   logic [8:0]  next_acc;
   logic        mon_hit;

   always_comb begin
      // Divides by 86400, 3600 and 60 as a shift and a reciprocal multiplication.
      day_prod = 51'(s_ff[31:7]) * 51'(DAY_RECIP);
      hour_prod = 27'(r_ff[16:4]) * 27'(HOUR_RECIP);
      min_prod = 21'(r_ff[11:2]) * 21'(MIN_RECIP);

      leap0 = is_leap(year_ff);
      lim = 6'(month_len(month_ff)) + ((month_ff == 4'd2) ? 6'(leap0) : 6'd0);
      bad = (year_ff < EPOCH_YEAR) || (month_ff < 4'd1) || (month_ff > LAST_MONTH) ||
            (hour_ff > 5'd23) || (minute_ff > 6'd59) || (second_ff > 6'd59) ||
            (day_ff == 5'd0) || (6'(day_ff) > lim);

      mid_sum = ((SW+1)'(lo_ff) + (SW+1)'(hi_ff) + (SW+1)'(1)) >> 1;
      db_lo = days_before(12'(lo_ff), YEAR_BEFORE_EPOCH + 12'(lo_ff));

      next_acc = month_start(mi_ff) + 9'(month_len(mi_ff)) +
                 ((mi_ff != 4'd1) ? 9'(leap_ff) : 9'd0);
      mon_hit = 16'(next_acc) > dayr_ff;
   end

   assign stat.srch_done = (lo_ff == hi_ff);
   assign stat.mon_done = mon_hit || (mi_ff == LAST_MONTH);

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            mode_ff <= req_mode;
            year_ff <= req_year;
            month_ff <= req_month;
            day_ff <= req_day;
            hour_ff <= req_hour;
            minute_ff <= req_minute;
            second_ff <= req_second;
            s_ff <= req_epoch_seconds;
         end
         OP_M0_DAYS: begin
            err_ff <= bad;
            days0_ff <= days_before(year_ff - EPOCH_YEAR, year_ff - 12'd1) +
                        21'(month_start(month_ff)) +
                        (((month_ff >= 4'd3) && leap0) ? 21'd1 : 21'd0) +
                        21'(day_ff) - 21'd1;
         end
         OP_M0_H: t_ff <= 32'(days0_ff) * 32'd24 + 32'(hour_ff);
         OP_M0_M: t_ff <= t_ff * 32'd60 + 32'(minute_ff);
         OP_M0_S: t_ff <= t_ff * 32'd60 + 32'(second_ff);
         OP_DIV_DAY: begin
            days_ff <= day_prod[50:35];
         end
         OP_DAY_DONE: begin
            wd_ff <= mod7(days_ff + 16'd3) + 3'd1;
            r_ff <= 17'(s_ff - 32'(days_ff) * 32'(SECS_PER_DAY));
         end
         OP_DIV_HOUR: begin
            hour_ff <= hour_prod[25:21];
         end
         OP_HOUR_DONE: begin
            r_ff <= r_ff - 17'(hour_ff) * 17'(SECS_PER_HOUR);
         end
         OP_DIV_MIN: begin
            minute_ff <= min_prod[19:14];
         end
         OP_MIN_DONE: begin
            second_ff <= 6'(r_ff - 17'(minute_ff) * 17'(SECS_PER_MIN));
            lo_ff <= '0;
            hi_ff <= SW'(YEAR_SEARCH_SPAN);
         end
         OP_SRCH_MID: begin
            mid_ff <= mid_sum[SW-1:0];
            dbmid_ff <= days_before(12'(mid_sum[SW-1:0]),
                                    YEAR_BEFORE_EPOCH + 12'(mid_sum[SW-1:0]));
         end
         OP_SRCH_CMP: begin
            if (dbmid_ff <= 21'(days_ff)) begin
               lo_ff <= mid_ff;
            end else begin
               hi_ff <= mid_ff - SW'(1);
            end
         end
         OP_YEAR_SUB: begin
            dayr_ff <= days_ff - db_lo[15:0];
            oyear_ff <= EPOCH_YEAR + 12'(lo_ff);
         end
         OP_MON_INIT: begin
            leap_ff <= is_leap(oyear_ff);
            acc_ff <= 9'd0;
            mi_ff <= 4'd1;
            mon_ff <= LAST_MONTH;
         end
         OP_MON_STEP: begin
            if (mon_hit) begin
               mon_ff <= mi_ff;
            end else begin
               acc_ff <= next_acc;
               mi_ff <= mi_ff + 4'd1;
            end
         end
         OP_OUT: begin
            if (!mode_ff) begin
               rsp_status <= err_ff;
               rsp_out_seconds <= err_ff ? 32'd0 : t_ff;
               rsp_out_year <= 12'd0;
               rsp_out_month <= 4'd0;
               rsp_out_day <= 5'd0;
               rsp_out_hour <= 5'd0;
               rsp_out_minute <= 6'd0;
               rsp_out_second <= 6'd0;
               rsp_weekday <= 3'd0;
            end else begin
               rsp_status <= 1'b0;
               rsp_out_seconds <= 32'd0;
               rsp_out_year <= oyear_ff;
               rsp_out_month <= mon_ff;
               rsp_out_day <= 5'(dayr_ff - 16'(acc_ff) + 16'd1);
               rsp_out_hour <= hour_ff;
               rsp_out_minute <= minute_ff;
               rsp_out_second <= second_ff;
               rsp_weekday <= wd_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### test/calendar_epoch_converter_tb.sv
// Self-checking testbench for the calendar to epoch-seconds converter.
module calendar_epoch_converter_tb;

   localparam logic MODE_TO_SECONDS = 1'b0;
   localparam logic MODE_TO_CALENDAR = 1'b1;
   localparam logic STATUS_BAD = 1'b1;
   localparam int SEARCH_SPAN = 256;
   localparam int SECS_IN_DAY = 86400;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic        mode;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [31:0] epoch_seconds;
   } cal_req_t;

   typedef struct packed {
      logic        status;
      logic [31:0] out_seconds;
      logic [11:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [4:0]  out_hour;
      logic [5:0]  out_minute;
      logic [5:0]  out_second;
      logic [2:0]  weekday;
   } cal_rsp_t;

   logic        clock;
   logic        reset;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = 1'b0;
   logic [11:0] req_year = '0;
   logic [3:0]  req_month = '0;
   logic [4:0]  req_day = '0;
   logic [4:0]  req_hour = '0;
   logic [5:0]  req_minute = '0;
   logic [5:0]  req_second = '0;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic [31:0] rsp_out_seconds;
   logic [11:0] rsp_out_year;
   logic [3:0]  rsp_out_month;
   logic [4:0]  rsp_out_day;
   logic [4:0]  rsp_out_hour;
   logic [5:0]  rsp_out_minute;
   logic [5:0]  rsp_out_second;
   logic [2:0]  rsp_weekday;

   cal_rsp_t expected_results[$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   bit no_gaps = 1'b0;
   int hold_off_cycles = 0;

   calendar_epoch_converter DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_mode(req_mode), .req_year(req_year), .req_month(req_month),
      .req_day(req_day), .req_hour(req_hour), .req_minute(req_minute),
      .req_second(req_second), .req_epoch_seconds(req_epoch_seconds),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_out_seconds(rsp_out_seconds),
      .rsp_out_year(rsp_out_year), .rsp_out_month(rsp_out_month),
      .rsp_out_day(rsp_out_day), .rsp_out_hour(rsp_out_hour),
      .rsp_out_minute(rsp_out_minute), .rsp_out_second(rsp_out_second),
      .rsp_weekday(rsp_weekday)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic int unsigned days_in_month(int unsigned m, int unsigned leap);
      int unsigned lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      return lens[m] + ((m == 2) ? leap : 0);
   endfunction

   function automatic int unsigned leap_year(int unsigned y);
      return ((y % 400) == 0 || ((y % 4) == 0 && (y % 100) != 0)) ? 1 : 0;
   endfunction

   // Days from the epoch to the first of January of year 1970 + n.
   function automatic int unsigned days_to_year(int unsigned n);
      int unsigned y;
      y = 1969 + n;
      return 365 * n + y / 4 - y / 100 + y / 400 - 477;
   endfunction

   function automatic cal_rsp_t convert_time(cal_req_t r);
      cal_rsp_t res;
      int unsigned leap, days, t, rem, lo, hi, mid, acc, mon;
      res = '0;
      if (r.mode == MODE_TO_SECONDS) begin
         leap = leap_year(r.year);
         if (r.year < 1970 || r.month < 1 || r.month > 12 || r.hour > 23 ||
             r.minute > 59 || r.second > 59 || r.day < 1 ||
             r.day > days_in_month(r.month, leap)) begin
            res.status = STATUS_BAD;
            return res;
         end
         days = days_to_year(r.year - 1970);
         for (int m = 1; m < r.month; m++) days += days_in_month(m, leap);
         days += r.day - 1;
         t = days * 24 + r.hour;
         t = t * 60 + r.minute;
         t = t * 60 + r.second;
         res.out_seconds = t;
      end else begin
         days = r.epoch_seconds / SECS_IN_DAY;
         rem = r.epoch_seconds % SECS_IN_DAY;
         res.weekday = 3'(((days + 3) % 7) + 1);
         lo = 0;
         hi = SEARCH_SPAN;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (days_to_year(mid) <= days) lo = mid;
            else hi = mid - 1;
         end
         days -= days_to_year(lo);
         leap = leap_year(1970 + lo);
         acc = 0;
         mon = 12;
         for (int m = 1; m <= 12; m++) begin
            if (acc + days_in_month(m, leap) > days) begin
               mon = m;
               break;
            end
            acc += days_in_month(m, leap);
         end
         res.out_year = 12'(1970 + lo);
         res.out_month = 4'(mon);
         res.out_day = 5'(days - acc + 1);
         res.out_hour = 5'(rem / 3600);
         res.out_minute = 6'((rem % 3600) / 60);
         res.out_second = 6'(rem % 60);
      end
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s is %0d, expected %0d", $realtime, field, got, want);
      mismatch_count++;
   endtask

   // Results are checked before the new transaction's prediction is queued.
   always @(posedge clock) begin
      cal_rsp_t want;
      cal_req_t taken;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result arrived with nothing expected", $realtime);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_out_seconds !== want.out_seconds)
               report_mismatch("out_seconds", rsp_out_seconds, want.out_seconds);
            if (rsp_out_year !== want.out_year)
               report_mismatch("out_year", rsp_out_year, want.out_year);
            if (rsp_out_month !== want.out_month)
               report_mismatch("out_month", rsp_out_month, want.out_month);
            if (rsp_out_day !== want.out_day)
               report_mismatch("out_day", rsp_out_day, want.out_day);
            if (rsp_out_hour !== want.out_hour)
               report_mismatch("out_hour", rsp_out_hour, want.out_hour);
            if (rsp_out_minute !== want.out_minute)
               report_mismatch("out_minute", rsp_out_minute, want.out_minute);
            if (rsp_out_second !== want.out_second)
               report_mismatch("out_second", rsp_out_second, want.out_second);
            if (rsp_weekday !== want.weekday)
               report_mismatch("weekday", rsp_weekday, want.weekday);
         end
      end
      if (!reset && req_valid && req_ready) begin
         taken = {req_mode, req_year, req_month, req_day, req_hour, req_minute,
                  req_second, req_epoch_seconds};
         expected_results.push_back(convert_time(taken));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // The receiver draws a wait before each result, or a long hold-off on request.
   initial begin
      int wait_cycles;
      @(negedge reset);
      forever begin
         if (hold_off_cycles > 0) begin
            wait_cycles = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            wait_cycles = no_gaps ? 0 : $urandom_range(0, 19);
         end
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_item(cal_req_t r);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_mode, req_year, req_month, req_day, req_hour, req_minute, req_second,
       req_epoch_seconds} <= r;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   function automatic cal_req_t calendar_item(int unsigned y, int unsigned mo,
                                              int unsigned d, int unsigned h,
                                              int unsigned mi, int unsigned s);
      cal_req_t r;
      r = {1'b0, 12'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(s), 32'($urandom)};
      r.mode = MODE_TO_SECONDS;
      return r;
   endfunction

   function automatic cal_req_t epoch_item(logic [31:0] secs);
      cal_req_t r;
      r = cal_req_t'({$urandom, $urandom});
      r.mode = MODE_TO_CALENDAR;
      r.epoch_seconds = secs;
      return r;
   endfunction

   function automatic cal_req_t random_item();
      cal_req_t r;
      int unsigned y, mo;
      if ($urandom_range(0, 1) == 1) return epoch_item($urandom);
      y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(1970, 2200);
      mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
      r = calendar_item(y, mo, $urandom_range(1, days_in_month(mo % 13, leap_year(y))),
                        $urandom_range(0, 23), $urandom_range(0, 59),
                        $urandom_range(0, 59));
      // Some items carry one corrupt field at random.
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: r.day = 5'($urandom);
            1: r.hour = 5'($urandom);
            2: r.minute = 6'($urandom);
            default: r.second = 6'($urandom);
         endcase
      end
      return r;
   endfunction

   task automatic test_calendar_limits();
      send_item(calendar_item(1970, 1, 1, 0, 0, 0));
      send_item(calendar_item(1969, 12, 31, 23, 59, 59));
      send_item(calendar_item(2106, 2, 7, 6, 28, 15));
      send_item(calendar_item(2106, 2, 7, 6, 28, 16));
      send_item(calendar_item(4095, 12, 31, 23, 59, 59));
      send_item(calendar_item(0, 0, 0, 31, 63, 63));
      send_item(calendar_item(2000, 13, 1, 0, 0, 0));
      send_item(calendar_item(2000, 15, 1, 0, 0, 0));
      send_item(calendar_item(2000, 4, 31, 0, 0, 0));
      send_item(calendar_item(2000, 5, 0, 0, 0, 0));
      send_item(calendar_item(2000, 5, 1, 24, 0, 0));
      send_item(calendar_item(2000, 5, 1, 0, 60, 0));
      send_item(calendar_item(2000, 5, 1, 0, 0, 60));
   endtask

   task automatic test_leap_days();
      send_item(calendar_item(2024, 2, 29, 12, 0, 0));
      send_item(calendar_item(2023, 2, 29, 12, 0, 0));
      send_item(calendar_item(2100, 2, 29, 0, 0, 0));
      send_item(calendar_item(2000, 2, 29, 0, 0, 0));
      send_item(calendar_item(2024, 3, 31, 0, 0, 0));
      send_item(calendar_item(2023, 1, 31, 0, 0, 0));
   endtask

   task automatic test_epoch_limits();
      send_item(epoch_item(32'd0));
      send_item(epoch_item(32'hFFFF_FFFF));
      send_item(epoch_item(32'd951782400));
      send_item(epoch_item(32'd951868799));
      send_item(epoch_item(32'd4102444799));
      send_item(epoch_item(32'd86399));
   endtask

   task automatic test_random_mix();
      for (int i = 0; i < 500; i++) begin
         // One stretch of fifty items in every two hundred runs back to back.
         no_gaps = ((i / 50) % 4) == 3;
         send_item(random_item());
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_output_stall();
      hold_off_cycles = 300;
      no_gaps = 1'b1;
      for (int i = 0; i < 12; i++) send_item(random_item());
      no_gaps = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_calendar_limits();
      test_leap_days();
      test_epoch_limits();
      test_output_stall();
      test_random_mix();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### calendar_epoch_converter.f
sv/cec_pkg.sv
sv/cec_ctrl.sv
sv/cec_datapath.sv
sv/calendar_epoch_converter.sv
test/calendar_epoch_converter_tb.sv
